FILE: rtl/mbrx_pkg.sv
package mbrx_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TICKS   = 1'd1;

	localparam logic [1:0] FUNC_BYTE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	localparam logic [2:0] ST_OWN       = 3'd0;
	localparam logic [2:0] ST_BROADCAST = 3'd1;
	localparam logic [2:0] ST_FOREIGN   = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;
	localparam logic [2:0] ST_CRC_ERR   = 3'd5;

	localparam logic [7:0]  ADDR_BROADCAST = 8'h00;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [15:0] CNT_MAX        = 16'hFFFF;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [2:0]  status;
		logic [7:0]  frame_address;
		logic [7:0]  pdu_length;
		logic [7:0]  read_data;
		logic [15:0] frames_seen;
		logic [15:0] own_frames;
		logic [15:0] crc_errors;
		logic [15:0] short_frames;
		logic [15:0] overflows;
	} out_item_t;

	typedef struct packed {
		logic [15:0] frames;
		logic [15:0] own;
		logic [15:0] crc_err;
		logic [15:0] short_fr;
		logic [15:0] ovf;
	} counts_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

	// fold one byte, LSB first, into the reflected CRC-16
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/mbrx_stream_if.sv
interface mbrx_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mbrx_ram.sv
module mbrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/modbus_rtu_frame_receiver.sv
// Modbus RTU receive framer with running CRC-16/MODBUS.
// Input channel "item": func selects a received byte (rx_byte), a one
// millisecond tick, or a read of the stored frame at read_index.
// Output channel "result": a frame verdict when the silence timer expires,
// or the stored byte for a read; bytes and other ticks give no result.
// Configuration: cfg_we/cfg_index/cfg_data write station_address (index 0)
// and silence_ticks (index 1); write only while the block is idle.
// Throughput is one item per cycle while stage one is free or advancing.
// A result is registered in stage one with the frame store read, then in
// the output register. Frame bytes live in a single-port-write,
// registered-read RAM of FRAME_BYTES entries; an item writes or reads it,
// never both. When the receiver stalls, one result waits in the output
// register and one more in the stage behind it; the input keeps taking
// items until both are full. Reset clears the write index, CRC, timer and
// all counters; the store is not cleared, so unwritten bytes read stale.
module modbus_rtu_frame_receiver #(
	parameter int FRAME_BYTES     = 256,
	parameter int MIN_FRAME_BYTES = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mbrx_stream_if.sink                      item,
	mbrx_stream_if.source                    result,
	input  logic                             cfg_we,
	input  logic [mbrx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbrx_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mbrx_pkg::*;

	localparam int AW  = $clog2(FRAME_BYTES);
	localparam int WIW = $clog2(FRAME_BYTES + 1);

	logic [7:0]     station_q, silence_ticks_q;
	logic [WIW-1:0] wr_idx_q, wr_idx_d;
	logic [15:0]    crc_q, crc_d;
	logic [7:0]     sc_q, sc_d, sc_inc;
	logic           armed_q, armed_d;
	logic [7:0]     addr_q, addr_d;
	counts_t        cnt_q, cnt_d;

	logic           valid_s1, valid_q;
	logic           kind_s1;
	logic [2:0]     status_s1;
	logic [7:0]     addr_s1, pdu_s1;
	logic           oob_s1;
	counts_t        cnt_s1;
	out_item_t      out_q;

	logic           in_acc, s1_adv, res_gen, res_kind, rd_oob;
	logic [2:0]     res_status;
	logic [7:0]     res_addr, res_pdu;
	logic           ram_we, ram_re;
	logic [7:0]     ram_rdata;
	logic [8:0]     len9;
	logic           wr_full;
	in_item_t       it;

	assign it      = item.payload;
	assign s1_adv  = valid_s1 && (!valid_q || result.ready);
	assign item.ready = !valid_s1 || s1_adv;
	assign in_acc  = item.valid && item.ready;
	assign wr_full = (wr_idx_q == WIW'(FRAME_BYTES));
	assign sc_inc  = sc_q + 8'd1;
	assign len9    = 9'(wr_idx_q);
	assign rd_oob  = ({1'b0, it.read_index} >= 9'(FRAME_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q       <= 8'd1;
			silence_ticks_q <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STATION_ADDRESS: station_q       <= cfg_data;
				REG_SILENCE_TICKS:   silence_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_idx_d   = wr_idx_q;
		crc_d      = crc_q;
		sc_d       = sc_q;
		armed_d    = armed_q;
		addr_d     = addr_q;
		cnt_d      = cnt_q;
		res_gen    = 1'b0;
		res_kind   = KIND_VERDICT;
		res_status = ST_OWN;
		res_addr   = 8'h00;
		res_pdu    = 8'h00;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		if (in_acc) begin
			case (it.func)
				FUNC_BYTE: begin
					if (wr_full) begin
						// drop the byte, restart the frame, leave the timer
						wr_idx_d  = '0;
						crc_d     = CRC_INIT;
						cnt_d.ovf = sat_inc(cnt_q.ovf);
					end else begin
						ram_we   = 1'b1;
						wr_idx_d = wr_idx_q + WIW'(1);
						crc_d    = crc_fold(crc_q, it.rx_byte);
						sc_d     = 8'd0;
						armed_d  = 1'b1;
						if (wr_idx_q == '0) begin
							addr_d = it.rx_byte;
						end
					end
				end
				FUNC_TICK: begin
					if (armed_q) begin
						sc_d = sc_inc;
						// a setting of zero closes on the first tick as well
						if (sc_inc >= silence_ticks_q) begin
							armed_d      = 1'b0;
							sc_d         = 8'd0;
							wr_idx_d     = '0;
							crc_d        = CRC_INIT;
							cnt_d.frames = cnt_q.frames + 16'd1;
							res_gen      = 1'b1;
							if (wr_idx_q == '0) begin
								res_status = ST_EMPTY;
							end else if (wr_idx_q < WIW'(MIN_FRAME_BYTES)) begin
								res_status     = ST_SHORT;
								res_addr       = addr_q;
								cnt_d.short_fr = sat_inc(cnt_q.short_fr);
							end else begin
								res_addr = addr_q;
								res_pdu  = 8'(len9 - 9'd3);
								if (crc_q != 16'h0000) begin
									res_status    = ST_CRC_ERR;
									cnt_d.crc_err = sat_inc(cnt_q.crc_err);
								end else if (addr_q == ADDR_BROADCAST) begin
									res_status = ST_BROADCAST;
								end else if (addr_q == station_q) begin
									res_status = ST_OWN;
									cnt_d.own  = cnt_q.own + 16'd1;
								end else begin
									res_status = ST_FOREIGN;
								end
							end
						end
					end
				end
				FUNC_READ: begin
					res_gen  = 1'b1;
					res_kind = KIND_READ;
					ram_re   = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			crc_q    <= CRC_INIT;
			sc_q     <= 8'd0;
			armed_q  <= 1'b0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			wr_idx_q <= wr_idx_d;
			crc_q    <= crc_d;
			sc_q     <= sc_d;
			armed_q  <= armed_d;
			cnt_q    <= cnt_d;
			if (in_acc) begin
				valid_s1 <= res_gen;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		if (in_acc && res_gen) begin
			kind_s1   <= res_kind;
			status_s1 <= res_status;
			addr_s1   <= res_addr;
			pdu_s1    <= res_pdu;
			oob_s1    <= rd_oob;
			cnt_s1    <= cnt_d;
		end
		if (s1_adv) begin
			out_q.result_kind   <= kind_s1;
			out_q.status        <= status_s1;
			out_q.frame_address <= addr_s1;
			out_q.pdu_length    <= pdu_s1;
			out_q.read_data     <= (kind_s1 == KIND_READ && !oob_s1) ? ram_rdata : 8'h00;
			out_q.frames_seen   <= cnt_s1.frames;
			out_q.own_frames    <= cnt_s1.own;
			out_q.crc_errors    <= cnt_s1.crc_err;
			out_q.short_frames  <= cnt_s1.short_fr;
			out_q.overflows     <= cnt_s1.ovf;
		end
	end

	assign result.valid   = valid_q;
	assign result.payload = out_q;

	mbrx_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q[AW-1:0]),
		.wdata (it.rx_byte),
		.re    (ram_re),
		.raddr (it.read_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	a_wr_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= WIW'(FRAME_BYTES))
		else $error("frame write index past store depth");

	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> sc_q == 8'd0)
		else $error("silence count running while timer disarmed");

	a_byte_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && it.func == FUNC_BYTE && !wr_full) |=> (armed_q && sc_q == 8'd0))
		else $error("stored byte did not restart silence timer");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q.ovf == CNT_MAX |=> cnt_q.ovf == CNT_MAX)
		else $error("overflow count wrapped");

	a_s1_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(status_s1) && $stable(kind_s1)))
		else $error("pending result lost in stage one");
endmodule
